@@ rtl/core/iss_pkg.sv @@
// Package for the indexed sequence store: sizes, action and status codes,
// and the structs shared by the top level and the shift cells.
// No dependencies.
`default_nettype none

package iss_pkg;

  // Store sizing
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  // Width used for position compares and cell indexes
  localparam int IDX_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Action codes
  localparam logic [2:0] ACT_READ      = 3'd0;
  localparam logic [2:0] ACT_INS_FRONT = 3'd1;
  localparam logic [2:0] ACT_INS_BACK  = 3'd2;
  localparam logic [2:0] ACT_INS_POS   = 3'd3;
  localparam logic [2:0] ACT_DELETE    = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Cell operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } iss_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
  } iss_out_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } iss_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/iss_cell.sv @@
// One shift cell of the indexed sequence store: holds one entry and takes
// its neighbor's entry on insert or delete. Depends on iss_pkg.
`default_nettype none

module iss_cell
  import iss_pkg::*;
(
  input  wire logic             clk,
  input  wire iss_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [VAL_W-1:0] left_entry,
  input  wire logic [VAL_W-1:0] right_entry,
  output logic      [VAL_W-1:0] entry,
  output logic      [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] entry_r;
  logic [VAL_W-1:0] entry_nxt;
  logic             at_pos;
  logic             past_pos;

  assign at_pos   = (cell_idx == ctl.pos);
  assign past_pos = (cell_idx > ctl.pos);

  // Next entry: shift up behind an insert, shift down from a delete
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_INS: begin
        if (past_pos) begin
          entry_nxt = left_entry;
        end else if (at_pos) begin
          entry_nxt = ctl.value;
        end
      end
      OP_DEL: begin
        if (past_pos || at_pos) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry   = entry_r;
  // Contribution to the read OR bus
  assign rd_data = at_pos ? entry_r : '0;

endmodule

`default_nettype wire

@@ rtl/core/indexed_sequence_store_unit.sv @@
// Top level of the indexed sequence store: command decode, count register,
// a row of iss_cell shift cells and the registered result. Depends on
// iss_pkg and iss_cell.
//
//   channel | ports                     | transfer when
//   --------+---------------------------+----------------------------
//   input   | start, busy, in_data      | start && !busy at clk edge
//   result  | out_valid, out_data       | out_valid at clk edge
//
// For each item, the accept edge latches the decoded command, and in the
// following cycle (busy high) every cell shifts in parallel and the read OR
// bus is sampled into the output register. The result strobe comes in the
// cycle after that, while the next item can already be taken.
// Reset (rst_n low, synchronous) clears count and control; entries are not
// cleared. The receiver cannot stall, so results never wait.
`default_nettype none

module indexed_sequence_store_unit
  import iss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire iss_in_t in_data,
  output logic         out_valid,
  output iss_out_t     out_data
);

  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  iss_ctl_t         ctl_r;
  iss_ctl_t         ctl_nxt;
  logic [1:0]       st_r;
  logic [1:0]       st_nxt;
  logic             rd_r;
  logic             rd_nxt;
  logic             out_valid_r;
  iss_out_t         out_r;
  iss_out_t         out_nxt;
  iss_ctl_t         cell_ctl;
  logic             accept;

  logic [IDX_W-1:0] pos_w;
  logic [IDX_W-1:0] cnt_w;
  logic [IDX_W-1:0] ins_pos;

  logic [VAL_W-1:0] entry_q [CAPACITY];
  logic [VAL_W-1:0] rd_q    [CAPACITY];
  logic [VAL_W-1:0] rd_bus;

  assign accept = start && !busy_r;
  assign pos_w  = IDX_W'(in_data.position);
  assign cnt_w  = IDX_W'(count_r);

  // Command decode at accept time
  always_comb begin
    ctl_nxt.op    = OP_NONE;
    ctl_nxt.pos   = pos_w;
    ctl_nxt.value = in_data.value;
    st_nxt        = ST_RANGE;
    rd_nxt        = 1'b0;
    ins_pos       = pos_w;
    case (in_data.action)
      ACT_INS_FRONT: ins_pos = '0;
      ACT_INS_BACK:  ins_pos = cnt_w;
      default:       ins_pos = pos_w;
    endcase
    unique case (in_data.action)
      ACT_READ: begin
        rd_nxt = 1'b1;
        st_nxt = (pos_w < cnt_w) ? ST_DONE : ST_RANGE;
      end
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
        ctl_nxt.pos = ins_pos;
        if (ins_pos > cnt_w) begin
          st_nxt = ST_RANGE;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          st_nxt     = ST_DONE;
          ctl_nxt.op = OP_INS;
        end
      end
      ACT_DELETE: begin
        if (pos_w < cnt_w) begin
          st_nxt     = ST_DONE;
          ctl_nxt.op = OP_DEL;
        end
      end
      default: st_nxt = ST_RANGE;
    endcase
  end

  // Command stage; payload fields load on accept without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ctl_r.op <= OP_NONE;
    end else begin
      busy_r   <= accept;
      ctl_r.op <= accept ? ctl_nxt.op : OP_NONE;
    end
    if (accept) begin
      ctl_r.pos   <= ctl_nxt.pos;
      ctl_r.value <= ctl_nxt.value;
      st_r        <= st_nxt;
      rd_r        <= rd_nxt;
    end
  end

  // Cells act only in the execute cycle
  always_comb begin
    cell_ctl    = ctl_r;
    cell_ctl.op = busy_r ? ctl_r.op : OP_NONE;
  end

  // Row of shift cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_e;
    logic [VAL_W-1:0] right_e;
    if (i == 0) begin : g_first
      assign left_e = ctl_r.value;
    end else begin : g_mid_l
      assign left_e = entry_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry_q[i];
    end else begin : g_mid_r
      assign right_e = entry_q[i+1];
    end
    iss_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .cell_idx    (IDX_W'(i)),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entry_q[i]),
      .rd_data     (rd_q[i])
    );
  end

  // Read bus: at most one cell drives nonzero
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd_q[k];
    end
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    case (cell_ctl.op)
      OP_INS:  count_nxt = count_r + CNT_W'(1);
      OP_DEL:  count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_comb begin
    out_nxt.status = st_r;
    if (rd_r && (st_r == ST_DONE)) begin
      out_nxt.read_value = rd_bus;
    end else if (rd_r) begin
      out_nxt.read_value = '1;
    end else begin
      out_nxt.read_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("busy held longer than one cycle");

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result without execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ST_FULL)) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for indexed_sequence_store_unit: random and directed read/insert/delete
// commands are checked against a queue-based model of the stored sequence.
// Depends on iss_pkg and the indexed_sequence_store_unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import iss_pkg::*;

  // Action codes the block does not define; they must leave the store unchanged and report ST_RANGE
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int IDLE_PCT    = 18;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    iss_in_t cmd;
    bit      wait_drain;  // hold this command until all results are back
    bit      no_gap;      // never idle before this command
  } cmd_entry_t;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  iss_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  iss_out_t out_data;

  cmd_entry_t              cmd_queue[$];
  iss_out_t                result_queue[$];
  logic signed [VAL_W-1:0] seq_entries[$];
  int                      gen_count = 0;
  int                      err_count = 0;
  int                      cycle_cnt = 0;

  indexed_sequence_store_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Insert into the sequence model; range check comes before full check
  function automatic logic [1:0] seq_insert(int pos, logic signed [VAL_W-1:0] val);
    if (pos > seq_entries.size()) return ST_RANGE;
    if (seq_entries.size() >= CAPACITY) return ST_FULL;
    seq_entries.insert(pos, val);
    return ST_DONE;
  endfunction

  // Apply one command to the sequence model and return its result
  function automatic iss_out_t seq_apply(iss_in_t cmd);
    iss_out_t res;
    int       pos;
    pos = int'(cmd.position);
    res.read_value = '0;
    res.status     = ST_DONE;
    case (cmd.action)
      ACT_READ: begin
        if (pos < seq_entries.size()) begin
          res.read_value = seq_entries[pos];
        end else begin
          res.read_value = -1;
          res.status     = ST_RANGE;
        end
      end
      ACT_INS_FRONT: res.status = seq_insert(0, cmd.value);
      ACT_INS_BACK:  res.status = seq_insert(seq_entries.size(), cmd.value);
      ACT_INS_POS:   res.status = seq_insert(pos, cmd.value);
      ACT_DELETE: begin
        if (pos >= seq_entries.size()) res.status = ST_RANGE;
        else seq_entries.delete(pos);
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, exp_val, cycle_cnt);
    err_count++;
  endtask

  // Queue a command; gen_count tracks the fill level so positions can be aimed
  task automatic add_cmd(logic [2:0] act, int pos, logic [VAL_W-1:0] val,
                         bit drain = 1'b0, bit nogap = 1'b0);
    cmd_entry_t e;
    e.cmd.action   = act;
    e.cmd.position = pos[POS_W-1:0];
    e.cmd.value    = val;
    e.wait_drain   = drain;
    e.no_gap       = nogap;
    cmd_queue.push_back(e);
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: if (gen_count < CAPACITY) gen_count++;
      ACT_INS_POS: if (pos <= gen_count && gen_count < CAPACITY) gen_count++;
      ACT_DELETE:  if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // Random command, mix set by insert and delete percentages
  task automatic rand_cmd(int ins_pct, int del_pct, bit drain, bit nogap);
    int               r;
    int               pos;
    logic [2:0]       act;
    logic [VAL_W-1:0] val;
    r = $urandom_range(99, 0);
    if (r < 3) begin
      act = ACT_UNUSED_LO + 3'($urandom_range(ACT_UNUSED_HI - ACT_UNUSED_LO, 0));
    end else if (r < 3 + ins_pct) begin
      case ($urandom_range(2, 0))
        0:       act = ACT_INS_FRONT;
        1:       act = ACT_INS_BACK;
        default: act = ACT_INS_POS;
      endcase
    end else if (r < 3 + ins_pct + del_pct) begin
      act = ACT_DELETE;
    end else begin
      act = ACT_READ;
    end
    // mostly in-range positions, some anywhere in the field
    if ($urandom_range(99, 0) < 15) pos = $urandom_range(127, 0);
    else if (act == ACT_INS_POS) pos = $urandom_range(gen_count, 0);
    else if (gen_count > 0) pos = $urandom_range(gen_count - 1, 0);
    else pos = 0;
    case ($urandom_range(19, 0))
      0:       val = 32'h7FFF_FFFF;
      1:       val = 32'h8000_0000;
      2:       val = 32'hFFFF_FFFF;
      3:       val = 32'h0000_0000;
      default: val = $urandom();
    endcase
    add_cmd(act, pos, val, drain, nogap);
  endtask

  // Driver: one transfer per start && !busy edge; start held while busy
  always @(posedge clk) begin
    cmd_entry_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) result_queue.push_back(seq_apply(in_data));
      if (start && busy) begin
        // keep the current command on the bus
      end else if (cmd_queue.size() != 0 &&
                   !(cmd_queue[0].wait_drain && result_queue.size() != 0) &&
                   (cmd_queue[0].no_gap || $urandom_range(99, 0) >= IDLE_PCT)) begin
        nxt = cmd_queue.pop_front();
        start   <= 1'b1;
        in_data <= nxt.cmd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation
  always @(posedge clk) begin
    iss_out_t exp_res;
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected result, read_value", out_data.read_value, 0);
      end else begin
        exp_res = result_queue.pop_front();
        if (out_data.read_value !== exp_res.read_value)
          report_mismatch("read_value", out_data.read_value, exp_res.read_value);
        if (out_data.status !== exp_res.status)
          report_mismatch("status", out_data.status, exp_res.status);
      end
    end
  end

  initial begin
    // Directed: empty store, appends, extremes, middle insert/delete, bad actions
    add_cmd(ACT_READ, 0, 32'h0);
    add_cmd(ACT_READ, 127, 32'h0);
    add_cmd(ACT_DELETE, 0, 32'h0);
    add_cmd(ACT_INS_POS, 1, 32'h1234_5678);
    add_cmd(ACT_INS_POS, 0, 32'h7FFF_FFFF);
    add_cmd(ACT_INS_FRONT, 0, 32'h8000_0000);
    add_cmd(ACT_INS_BACK, 0, 32'hFFFF_FFFF);
    add_cmd(ACT_INS_POS, 3, 32'h0000_0000);
    add_cmd(ACT_INS_POS, 2, 32'h5A5A_5A5A);
    for (int i = 0; i < 5; i++) add_cmd(ACT_READ, i, 32'h0);
    add_cmd(ACT_READ, 5, 32'h0);
    add_cmd(ACT_READ, 127, 32'hFFFF_FFFF);
    add_cmd(ACT_INS_POS, 127, 32'hA5A5_A5A5);
    add_cmd(ACT_DELETE, 2, 32'h0);
    add_cmd(ACT_DELETE, 3, 32'h0);
    add_cmd(ACT_DELETE, 127, 32'h0);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      add_cmd(3'(a), 127, 32'hFFFF_FFFF);
    add_cmd(ACT_READ, 0, 32'h0);
    add_cmd(ACT_DELETE, 0, 32'h0);

    // Random: fill to full, mixed with a gap-free stretch, drain to empty, mixed
    for (int i = 0; i < 90; i++)  rand_cmd(70, 10, 1'b0, 1'b0);
    for (int i = 0; i < 200; i++) rand_cmd(35, 30, i == 0, i >= 50 && i < 170);
    for (int i = 0; i < 120; i++) rand_cmd(15, 60, i == 0, 1'b0);
    for (int i = 0; i < 90; i++)  rand_cmd(40, 40, i == 0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || start || result_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Timeout
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/iss_pkg.sv
rtl/core/iss_cell.sv
rtl/core/indexed_sequence_store_unit.sv
dv/tb_top.sv
